// ===== rtl/core/image_format_sniffer_unit_defines.svh =====
// assertion macros shared by the sniffer rtl
`ifndef IMAGE_FORMAT_SNIFFER_UNIT_DEFINES_SVH
`define IMAGE_FORMAT_SNIFFER_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
// property that must hold at every clock edge out of reset
`define IFS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// property that must hold in the cycle after a condition
`define IFS_ASSERT_NEXT(lbl, clk, rst_n, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error(msg);
`else
`define IFS_ASSERT(lbl, clk, rst_n, prop, msg)
`define IFS_ASSERT_NEXT(lbl, clk, rst_n, cond, prop, msg)
`endif
`endif

// ===== rtl/core/ifs_pkg.sv =====
// shared types, signature tables and format codes of the image format sniffer
`default_nettype none
package ifs_pkg;

	localparam int WINDOW_BYTES_DEF = 1024;

	// format codes, numbered in priority order
	typedef enum logic [3:0] {
		FMT_UNKNOWN = 4'd0,
		FMT_BMP     = 4'd1,
		FMT_DDS     = 4'd2,
		FMT_GIF     = 4'd3,
		FMT_ICNS    = 4'd4,
		FMT_JPG     = 4'd5,
		FMT_MNG     = 4'd6,
		FMT_PBM     = 4'd7,
		FMT_PGM     = 4'd8,
		FMT_PPM     = 4'd9,
		FMT_PNG     = 4'd10,
		FMT_SVG     = 4'd11,
		FMT_TIFF    = 4'd12,
		FMT_WEBP    = 4'd13,
		FMT_XBM     = 4'd14,
		FMT_XPM     = 4'd15
	} fmt_t;

	// prefix signatures, byte zero in the top bits, zero padded below
	localparam int SIG_COUNT  = 17;
	localparam int SIG_MAXLEN = 14;
	localparam int SIG_IDX_W  = $clog2(SIG_MAXLEN);

	typedef logic [8*SIG_MAXLEN-1:0] sig_t;

	localparam sig_t SIG_BYTES [SIG_COUNT] = '{
		{16'h424D, 96'h0},
		{24'h444453, 88'h0},
		{32'h47494638, 80'h0},
		{32'h69636E73, 80'h0},
		{16'hFFD8, 96'h0},
		{64'h8A4D4E47_0D0A1A0A, 48'h0},
		{16'h5031, 96'h0},
		{16'h5034, 96'h0},
		{16'h5032, 96'h0},
		{16'h5035, 96'h0},
		{16'h5033, 96'h0},
		{16'h5036, 96'h0},
		{64'h89504E47_0D0A1A0A, 48'h0},
		{32'h4D4D002A, 80'h0},
		{32'h49492A00, 80'h0},
		112'h52494646_72000000_57454250_5650,
		{72'h2F2A2058_504D202A_2F, 40'h0}
	};

	localparam int SIG_LEN [SIG_COUNT] = '{2, 3, 4, 4, 2, 8, 2, 2, 2, 2, 2, 2, 8, 4, 4, 14, 9};

	localparam fmt_t SIG_CODE [SIG_COUNT] = '{
		FMT_BMP, FMT_DDS, FMT_GIF, FMT_ICNS, FMT_JPG, FMT_MNG,
		FMT_PBM, FMT_PBM, FMT_PGM, FMT_PGM, FMT_PPM, FMT_PPM,
		FMT_PNG, FMT_TIFF, FMT_TIFF, FMT_WEBP, FMT_XPM
	};

	// substring patterns, byte zero in the top bits
	localparam int PAT_MAX    = 19;
	localparam int SVG_LEN    = 4;
	localparam int WIDTH_LEN  = 18;
	localparam int HEIGHT_LEN = 19;

	typedef logic [8*PAT_MAX-1:0] pat_t;

	localparam pat_t PAT_SVG    = {32'h3C737667, 120'h0};
	localparam pat_t PAT_WIDTH  = {144'h23646566_696E6520_6D61785F_77696474_6820, 8'h0};
	localparam pat_t PAT_HEIGHT = 152'h23646566_696E6520_6D61785F_68656967_687420;

	// per-cycle control handed to every matcher cell
	typedef struct packed {
		logic take;
		logic clear;
	} cell_ctl_t;

	function automatic logic [7:0] sig_byte(input int idx, input logic [SIG_IDX_W-1:0] pos);
		sig_t row;
		row = SIG_BYTES[idx];
		return row[8*(SIG_MAXLEN-1-int'(pos)) +: 8];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/ifs_byte_if.sv =====
// input channel carrying at most one file byte per transaction
`default_nettype none
interface ifs_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_present;
	logic       last;

	modport source(output valid, output data_byte, output byte_present, output last,
		input ready);
	modport sink(input valid, input data_byte, input byte_present, input last,
		output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ifs_code_if.sv =====
// output channel carrying one format code per transaction
`default_nettype none
interface ifs_code_if;
	logic       valid;
	logic       ready;
	logic [3:0] format_code;

	modport source(output valid, output format_code, input ready);
	modport sink(input valid, input format_code, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ifs_match_cell.sv =====
// one cell of a substring matcher chain: holds a token, passes it on a matching byte
`default_nettype none
module ifs_match_cell #(
	parameter logic [7:0] CHAR  = 8'h00,
	parameter logic       START = 1'b0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ifs_pkg::cell_ctl_t ctl,
	input  logic [7:0]        data_byte,
	input  logic              tok_in,
	output logic              tok,
	output logic              hit
);

	logic tok_q;

	// token register, restarts at the end of a file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= START;
		end else if (ctl.clear) begin
			tok_q <= START;
		end else if (ctl.take) begin
			tok_q <= tok_in;
		end
	end

	// token advances when this cell's character arrives
	assign hit = tok_q && (data_byte == CHAR);
	assign tok = tok_q;

endmodule
`default_nettype wire

// ===== rtl/core/ifs_substr_chain.sv =====
// substring matcher built from a row of token cells, one per pattern character
`default_nettype none
`include "image_format_sniffer_unit_defines.svh"
module ifs_substr_chain #(
	parameter int            LEN     = 4,
	parameter ifs_pkg::pat_t PATTERN = '0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ifs_pkg::cell_ctl_t ctl,
	input  logic [7:0]         data_byte,
	output logic               found
);
	import ifs_pkg::*;

	localparam logic [7:0] FIRST = PATTERN[8*(PAT_MAX-1) +: 8];

	logic [LEN-1:0] hit;
	logic [LEN-1:0] tok;
	logic [LEN-1:0] tok_in;
	logic           any_hit;
	logic           first_hit;
	logic           found_q;

	assign any_hit   = |hit;
	assign first_hit = (data_byte == FIRST);

	// token routing: advance on a hit, restart on a miss, wrap on completion
	always_comb begin
		tok_in    = '0;
		tok_in[0] = (!any_hit && !first_hit) || hit[LEN-1];
		tok_in[1] = hit[0] || (!any_hit && first_hit);
		for (int k = 2; k < LEN; k++) begin
			tok_in[k] = hit[k-1];
		end
	end

	for (genvar k = 0; k < LEN; k++) begin : g_cell
		ifs_match_cell #(
			.CHAR  (PATTERN[8*(PAT_MAX-1-k) +: 8]),
			.START ((k == 0) ? 1'b1 : 1'b0)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.data_byte (data_byte),
			.tok_in    (tok_in[k]),
			.tok       (tok[k]),
			.hit       (hit[k])
		);
	end

	// sticky found flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.clear) begin
			found_q <= 1'b0;
		end else if (ctl.take && hit[LEN-1]) begin
			found_q <= 1'b1;
		end
	end

	// includes the byte of the current transaction
	assign found = found_q || (ctl.take && hit[LEN-1]);

	`IFS_ASSERT(a_tok_onehot, clk, arst_n, $onehot(tok), "matcher token not one-hot")
	`IFS_ASSERT_NEXT(a_found_sticky, clk, arst_n, found_q && !ctl.clear, found_q,
		"found flag dropped without a clear")
	`IFS_ASSERT_NEXT(a_clear_restart, clk, arst_n, ctl.clear, tok[0] && !found_q,
		"matcher did not restart after a clear")

endmodule
`default_nettype wire

// ===== rtl/core/image_format_sniffer_unit.sv =====
// image format sniffer top level: one byte per cycle unless stalled, no bubbles between files
// the format code is registered and valid in the cycle after the transaction marked last
// throughput: one transaction per cycle; input stalls only while a held code is not taken
// the single output register is fed straight from the cell chains and prefix flags
// reset: arst_n at once clears position and output valid, sets alive flags, restarts tokens
`default_nettype none
`include "image_format_sniffer_unit_defines.svh"
module image_format_sniffer_unit #(
	parameter int WINDOW_BYTES = ifs_pkg::WINDOW_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	ifs_byte_if.sink          sniff_in,
	ifs_code_if.source        sniff_out
);
	import ifs_pkg::*;

	localparam int                POS_W = $clog2(WINDOW_BYTES + 1);
	localparam logic [POS_W-1:0]  WIN   = POS_W'(WINDOW_BYTES);

	logic [POS_W-1:0]     pos_q;
	logic [POS_W-1:0]     pos_nxt;
	logic [SIG_COUNT-1:0] alive_q;
	logic [SIG_COUNT-1:0] alive_nxt;
	logic [SIG_COUNT-1:0] sig_match;
	logic [15:0]          code_hit;
	logic                 accept;
	cell_ctl_t            ctl;
	logic                 svg_found;
	logic                 width_found;
	logic                 height_found;
	fmt_t                 best;
	logic                 out_valid_q;
	fmt_t                 fmt_q;

	// handshake: the output register frees up when its code is taken
	assign sniff_in.ready = !out_valid_q || sniff_out.ready;
	assign accept         = sniff_in.valid && sniff_in.ready;
	assign ctl.take       = accept && sniff_in.byte_present && (pos_q < WIN);
	assign ctl.clear      = accept && sniff_in.last;

	// prefix signature flags, one compare per signature at the current position
	always_comb begin
		for (int i = 0; i < SIG_COUNT; i++) begin
			alive_nxt[i] = alive_q[i] && !(ctl.take && (pos_q < POS_W'(SIG_LEN[i]))
				&& (sig_byte(i, pos_q[SIG_IDX_W-1:0]) != sniff_in.data_byte));
		end
	end

	assign pos_nxt = pos_q + POS_W'(ctl.take);

	// substring matchers
	ifs_substr_chain #(.LEN(SVG_LEN), .PATTERN(PAT_SVG)) u_svg (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.data_byte (sniff_in.data_byte),
		.found     (svg_found)
	);

	ifs_substr_chain #(.LEN(WIDTH_LEN), .PATTERN(PAT_WIDTH)) u_width (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.data_byte (sniff_in.data_byte),
		.found     (width_found)
	);

	ifs_substr_chain #(.LEN(HEIGHT_LEN), .PATTERN(PAT_HEIGHT)) u_height (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.data_byte (sniff_in.data_byte),
		.found     (height_found)
	);

	// decision: lowest format code whose test holds
	always_comb begin
		for (int i = 0; i < SIG_COUNT; i++) begin
			sig_match[i] = alive_nxt[i] && (pos_nxt >= POS_W'(SIG_LEN[i]));
		end
		code_hit = '0;
		for (int i = 0; i < SIG_COUNT; i++) begin
			if (sig_match[i]) begin
				code_hit[SIG_CODE[i]] = 1'b1;
			end
		end
		if (svg_found) begin
			code_hit[FMT_SVG] = 1'b1;
		end
		if (width_found && height_found) begin
			code_hit[FMT_XBM] = 1'b1;
		end
		best = FMT_UNKNOWN;
		for (int c = 15; c > 0; c--) begin
			if (code_hit[c]) begin
				best = fmt_t'(4'(c));
			end
		end
	end

	// per-file state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			alive_q <= '1;
		end else if (ctl.clear) begin
			pos_q   <= '0;
			alive_q <= '1;
		end else if (ctl.take) begin
			pos_q   <= pos_nxt;
			alive_q <= alive_nxt;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.clear) begin
			out_valid_q <= 1'b1;
		end else if (sniff_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			fmt_q <= best;
		end
	end

	assign sniff_out.valid       = out_valid_q;
	assign sniff_out.format_code = fmt_q;

	`IFS_ASSERT(a_pos_window, clk, arst_n, pos_q <= WIN, "byte position past the window")
	`IFS_ASSERT_NEXT(a_last_result, clk, arst_n, ctl.clear,
		out_valid_q && (pos_q == '0) && (alive_q == '1), "end of file not handled")
	`IFS_ASSERT_NEXT(a_hold_code, clk, arst_n, out_valid_q && !sniff_out.ready,
		out_valid_q && $stable(fmt_q), "held format code lost")

endmodule
`default_nettype wire
